// ===== sv/hsor_pkg.sv =====
// shared types and constants for the hysteresis smoother offset ramp unit
package hsor_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [15:0] LEVEL_TOP = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TARGET = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_MAX_MAGNITUDE   = 3'd0,
		REG_TICKS_PER_LEVEL = 3'd1,
		REG_TICKS_AT_TARGET = 3'd2,
		REG_HYSTERESIS      = 3'd3,
		REG_ADC_WIDTH       = 3'd4,
		REG_DAC_WIDTH       = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [14:0] max_magnitude;
		logic [15:0] ticks_per_level;
		logic [15:0] ticks_at_target;
		logic [15:0] hysteresis;
		logic [4:0]  adc_width;
		logic [4:0]  dac_width;
	} cfg_t;

	typedef struct packed {
		kind_t              op;
		logic [15:0]        blue;
		logic [15:0]        green;
		logic signed [15:0] target;
	} item_t;

endpackage

// ===== sv/hsor_front.sv =====
// front end: decodes the item kind and clamps the requested offset
module hsor_front (
	input  logic [1:0]         kind,
	input  logic [15:0]        blue_sample,
	input  logic [15:0]        green_sample,
	input  logic signed [15:0] new_target,
	input  logic [14:0]        max_magnitude,
	output hsor_pkg::item_t    item
);

	logic signed [16:0] req;
	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [16:0] clamped;

	always_comb begin
		req     = 17'(new_target);
		lim_pos = $signed({2'b00, max_magnitude});
		lim_neg = -lim_pos;
		clamped = req;
		if (req > lim_pos) begin
			clamped = lim_pos;
		end
		if (req < lim_neg) begin
			clamped = lim_neg;
		end
	end

	always_comb begin
		item.blue   = blue_sample;
		item.green  = green_sample;
		item.target = clamped[15:0];
		case (kind)
			hsor_pkg::KIND_SAMPLE: item.op = hsor_pkg::KIND_SAMPLE;
			hsor_pkg::KIND_TARGET: item.op = hsor_pkg::KIND_TARGET;
			hsor_pkg::KIND_TICK:   item.op = hsor_pkg::KIND_TICK;
			default:               item.op = hsor_pkg::KIND_NONE;
		endcase
	end

endmodule

// ===== sv/hsor_queue.sv =====
// short item queue between the front end and the execution stage
module hsor_queue #(
	parameter int unsigned DEPTH = hsor_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hsor_pkg::item_t push_item,
	output logic            full,
	output logic            nonempty,
	input  logic            pop,
	output hsor_pkg::item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hsor_pkg::item_t   entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/hsor_back.sv =====
// execution stage: state update, dac conversion and the result register
module hsor_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hsor_pkg::cfg_t     cfg,
	input  logic               head_valid,
	input  hsor_pkg::item_t    head,
	output logic               head_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        smooth_blue,
	output logic [15:0]        smooth_green,
	output logic signed [15:0] offset_now,
	output logic signed [15:0] offset_goal,
	output logic [15:0]        blue_drive,
	output logic [15:0]        green_drive
);

	logic [15:0]        blue_level_q;
	logic [15:0]        green_level_q;
	logic signed [15:0] applied_q;
	logic signed [15:0] goal_q;
	logic [15:0]        dwell_q;
	logic               out_valid_q;
	logic [15:0]        blue_drive_q;
	logic [15:0]        green_drive_q;

	logic [15:0]        blue_nx;
	logic [15:0]        green_nx;
	logic signed [15:0] applied_nx;
	logic signed [15:0] goal_nx;
	logic [15:0]        dwell_nx;
	logic [15:0]        dwell_inc;
	logic [16:0]        return_at;
	logic [15:0]        blue_diff;
	logic [15:0]        green_diff;
	logic [15:0]        blue_dac;
	logic [15:0]        green_dac;
	logic [4:0]         shift_dn;
	logic [4:0]         shift_up;
	logic signed [17:0] blue_sum;
	logic signed [17:0] green_sum;

	assign head_pop = head_valid && (!out_valid_q || !out_stall);

	function automatic logic [15:0] to_dac(logic [15:0] lvl, logic [4:0] adc, logic [4:0] dac,
		logic [4:0] dn, logic [4:0] up);
		logic [15:0] v;
		v = lvl;
		if (adc > dac) begin
			v = dn[4] ? '0 : (lvl >> dn[3:0]);
		end else if (adc < dac) begin
			v = up[4] ? '0 : (lvl << up[3:0]);
		end
		return v;
	endfunction

	function automatic logic [15:0] saturate(logic signed [17:0] s);
		logic [15:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > $signed({2'b00, hsor_pkg::LEVEL_TOP})) begin
			r = hsor_pkg::LEVEL_TOP;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	always_comb begin
		blue_nx    = blue_level_q;
		green_nx   = green_level_q;
		applied_nx = applied_q;
		goal_nx    = goal_q;
		dwell_nx   = dwell_q;
		blue_diff  = (blue_level_q > head.blue) ? blue_level_q - head.blue
			: head.blue - blue_level_q;
		green_diff = (green_level_q > head.green) ? green_level_q - head.green
			: head.green - green_level_q;
		dwell_inc  = (dwell_q != hsor_pkg::LEVEL_TOP) ? dwell_q + 16'd1 : dwell_q;
		return_at  = {1'b0, cfg.ticks_at_target} + {1'b0, cfg.ticks_per_level};
		case (head.op)
			hsor_pkg::KIND_SAMPLE: begin
				if (blue_diff > cfg.hysteresis) begin
					blue_nx = head.blue;
				end
				if (green_diff > cfg.hysteresis) begin
					green_nx = head.green;
				end
			end
			hsor_pkg::KIND_TARGET: begin
				goal_nx = head.target;
				if (head.target == applied_q && dwell_q > cfg.ticks_per_level) begin
					dwell_nx = cfg.ticks_per_level;
				end
			end
			hsor_pkg::KIND_TICK: begin
				dwell_nx = dwell_inc;
				if (goal_q != applied_q) begin
					if (dwell_inc >= cfg.ticks_per_level) begin
						applied_nx = (goal_q > applied_q) ? applied_q + 16'sd1
							: applied_q - 16'sd1;
						dwell_nx   = '0;
					end
				end else if (goal_q != 16'sd0 && {1'b0, dwell_inc} >= return_at) begin
					goal_nx = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		shift_dn  = cfg.adc_width - cfg.dac_width;
		shift_up  = cfg.dac_width - cfg.adc_width;
		blue_dac  = to_dac(blue_nx, cfg.adc_width, cfg.dac_width, shift_dn, shift_up);
		green_dac = to_dac(green_nx, cfg.adc_width, cfg.dac_width, shift_dn, shift_up);
		blue_sum  = $signed({2'b00, blue_dac}) - 18'(applied_nx);
		green_sum = $signed({2'b00, green_dac}) + 18'(applied_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_level_q  <= '0;
			green_level_q <= '0;
			applied_q     <= '0;
			goal_q        <= '0;
			dwell_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (head_pop) begin
				blue_level_q  <= blue_nx;
				green_level_q <= green_nx;
				applied_q     <= applied_nx;
				goal_q        <= goal_nx;
				dwell_q       <= dwell_nx;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			blue_drive_q  <= saturate(blue_sum);
			green_drive_q <= saturate(green_sum);
		end
	end

	assign out_valid    = out_valid_q;
	assign smooth_blue  = blue_level_q;
	assign smooth_green = green_level_q;
	assign offset_now   = applied_q;
	assign offset_goal  = goal_q;
	assign blue_drive   = blue_drive_q;
	assign green_drive  = green_drive_q;

endmodule

// ===== sv/hysteresis_smoother_offset_ramp_unit.sv =====
// top level of the hysteresis smoother offset ramp unit
// One item per clock cycle sustained while the output side does not stall.
// An accepted item is written into a two-entry queue; the execution stage
// takes the queue head once the result register is free or not stalled,
// updates the smoothed levels, offsets and dwell count, and loads the result
// register, so a result passes the queue entry and then the result register.
// in_stall rises only while the queue is full. Configuration writes take effect
// at the next clock edge and are meant for idle periods.
module hysteresis_smoother_offset_ramp_unit #(
	parameter int unsigned QUEUE_DEPTH = hsor_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [15:0]        blue_sample,
	input  logic [15:0]        green_sample,
	input  logic signed [15:0] new_target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        smooth_blue,
	output logic [15:0]        smooth_green,
	output logic signed [15:0] offset_now,
	output logic signed [15:0] offset_goal,
	output logic [15:0]        blue_drive,
	output logic [15:0]        green_drive
);

	hsor_pkg::cfg_t  cfg_q;
	hsor_pkg::item_t front_item;
	hsor_pkg::item_t head_item;
	logic            q_full;
	logic            q_nonempty;
	logic            q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_magnitude   <= '0;
			cfg_q.ticks_per_level <= 16'd1;
			cfg_q.ticks_at_target <= '0;
			cfg_q.hysteresis      <= '0;
			cfg_q.adc_width       <= 5'd10;
			cfg_q.dac_width       <= 5'd12;
		end else if (cfg_we) begin
			case (cfg_index)
				hsor_pkg::REG_MAX_MAGNITUDE:   cfg_q.max_magnitude   <= cfg_data[14:0];
				hsor_pkg::REG_TICKS_PER_LEVEL: cfg_q.ticks_per_level <= cfg_data;
				hsor_pkg::REG_TICKS_AT_TARGET: cfg_q.ticks_at_target <= cfg_data;
				hsor_pkg::REG_HYSTERESIS:      cfg_q.hysteresis      <= cfg_data;
				hsor_pkg::REG_ADC_WIDTH:       cfg_q.adc_width       <= cfg_data[4:0];
				hsor_pkg::REG_DAC_WIDTH:       cfg_q.dac_width       <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;

	hsor_front u_front (
		.kind          (kind),
		.blue_sample   (blue_sample),
		.green_sample  (green_sample),
		.new_target    (new_target),
		.max_magnitude (cfg_q.max_magnitude),
		.item          (front_item)
	);

	hsor_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_item (front_item),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.pop       (q_pop),
		.pop_item  (head_item)
	);

	hsor_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (q_nonempty),
		.head         (head_item),
		.head_pop     (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.smooth_blue  (smooth_blue),
		.smooth_green (smooth_green),
		.offset_now   (offset_now),
		.offset_goal  (offset_goal),
		.blue_drive   (blue_drive),
		.green_drive  (green_drive)
	);

endmodule

// ===== sv/hsor_checker.sv =====
// port-level checker for the hysteresis smoother offset ramp unit and its bind
module hsor_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        smooth_blue,
	input logic [15:0]        smooth_green,
	input logic signed [15:0] offset_now,
	input logic signed [15:0] offset_goal,
	input logic [15:0]        blue_drive,
	input logic [15:0]        green_drive
);

	logic signed [15:0] last_now_q;
	logic               seen_q;
	logic signed [16:0] step;
	logic               step_ok;

	assign step    = 17'(offset_now) - 17'(last_now_q);
	assign step_ok = (step == 17'sd0) || (step == 17'sd1) || (step == -17'sd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_now_q <= '0;
			seen_q     <= 1'b0;
		end else if (out_valid && !out_stall) begin
			last_now_q <= offset_now;
			seen_q     <= 1'b1;
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(smooth_blue) && $stable(smooth_green)
			&& $stable(offset_now) && $stable(offset_goal) && $stable(blue_drive)
			&& $stable(green_drive))
		else $error("stalled result changed");

	// applied offset ramps by at most one unit per result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && seen_q |-> step_ok)
		else $error("applied offset jumped");

	// clamped offsets never reach the negative extreme
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> offset_goal != -16'sd32768 && offset_now != -16'sd32768)
		else $error("offset out of range");

	// first result after reset has zero applied offset
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_q |-> offset_now == 16'sd0)
		else $error("first result has nonzero applied offset");

endmodule

bind hysteresis_smoother_offset_ramp_unit hsor_checker u_hsor_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the hysteresis smoother offset ramp unit
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_TICKS = 40;

	typedef struct packed {
		logic [15:0]        smooth_blue;
		logic [15:0]        smooth_green;
		logic signed [15:0] offset_now;
		logic signed [15:0] offset_goal;
		logic [15:0]        blue_drive;
		logic [15:0]        green_drive;
	} drive_result_t;

	class offset_ramp_tracker;
		int max_mag, ticks_level, ticks_hold, hyst, in_res, out_res;
		int blue_lvl, green_lvl, applied, goal, dwell;
		int failures;
		drive_result_t expected_drives[$];

		function new();
			max_mag = 0;
			ticks_level = 1;
			ticks_hold = 0;
			hyst = 0;
			in_res = 10;
			out_res = 12;
			blue_lvl = 0;
			green_lvl = 0;
			applied = 0;
			goal = 0;
			dwell = 0;
			failures = 0;
		endfunction

		function void write_reg(hsor_pkg::reg_index_t idx, logic [15:0] data);
			case (idx)
				hsor_pkg::REG_MAX_MAGNITUDE:   max_mag = data[14:0];
				hsor_pkg::REG_TICKS_PER_LEVEL: ticks_level = data;
				hsor_pkg::REG_TICKS_AT_TARGET: ticks_hold = data;
				hsor_pkg::REG_HYSTERESIS:      hyst = data;
				hsor_pkg::REG_ADC_WIDTH:       in_res = data[4:0];
				hsor_pkg::REG_DAC_WIDTH:       out_res = data[4:0];
				default: ;
			endcase
		endfunction

		function int smoothed(int old, int fresh);
			int diff;
			diff = (old > fresh) ? old - fresh : fresh - old;
			return (diff > hyst) ? fresh : old;
		endfunction

		function int dac_value(int lvl);
			int v, d;
			v = lvl;
			if (in_res > out_res) begin
				d = in_res - out_res;
				v = (d >= 16) ? 0 : (v >> d);
			end else if (in_res < out_res) begin
				d = out_res - in_res;
				v = (d >= 16) ? 0 : ((v << d) & int'(hsor_pkg::LEVEL_TOP));
			end
			return v;
		endfunction

		function logic [15:0] saturate(int s);
			if (s < 0)
				return 16'd0;
			if (s > int'(hsor_pkg::LEVEL_TOP))
				return hsor_pkg::LEVEL_TOP;
			return s[15:0];
		endfunction

		function void note_item(hsor_pkg::kind_t op, logic [15:0] b, logic [15:0] g,
				logic signed [15:0] t);
			int req;
			drive_result_t r;
			case (op)
				hsor_pkg::KIND_SAMPLE: begin
					blue_lvl = smoothed(blue_lvl, b);
					green_lvl = smoothed(green_lvl, g);
				end
				hsor_pkg::KIND_TARGET: begin
					req = t;
					if (req > max_mag)
						req = max_mag;
					if (req < -max_mag)
						req = -max_mag;
					goal = req;
					if (goal == applied && dwell > ticks_level)
						dwell = ticks_level;
				end
				hsor_pkg::KIND_TICK: begin
					if (dwell < int'(hsor_pkg::LEVEL_TOP))
						dwell++;
					if (goal != applied) begin
						if (dwell >= ticks_level) begin
							applied += (goal > applied) ? 1 : -1;
							dwell = 0;
						end
					end else if (goal != 0 && dwell >= ticks_hold + ticks_level) begin
						goal = 0;
					end
				end
				default: ;
			endcase
			r.smooth_blue = blue_lvl[15:0];
			r.smooth_green = green_lvl[15:0];
			r.offset_now = applied[15:0];
			r.offset_goal = goal[15:0];
			r.blue_drive = saturate(dac_value(blue_lvl) - applied);
			r.green_drive = saturate(dac_value(green_lvl) + applied);
			expected_drives.push_back(r);
		endfunction

		function void check_result(drive_result_t got);
			drive_result_t want;
			if (expected_drives.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: %p", got);
				return;
			end
			want = expected_drives.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display({"mismatch (expected/actual): blue %0d/%0d green %0d/%0d ",
						"now %0d/%0d goal %0d/%0d bdrv %0d/%0d gdrv %0d/%0d"},
						want.smooth_blue, got.smooth_blue,
						want.smooth_green, got.smooth_green,
						want.offset_now, got.offset_now,
						want.offset_goal, got.offset_goal,
						want.blue_drive, got.blue_drive,
						want.green_drive, got.green_drive);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [15:0]        blue_sample;
	logic [15:0]        green_sample;
	logic signed [15:0] new_target;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        smooth_blue;
	logic [15:0]        smooth_green;
	logic signed [15:0] offset_now;
	logic signed [15:0] offset_goal;
	logic [15:0]        blue_drive;
	logic [15:0]        green_drive;

	bit no_idle;
	int stall_left;
	int run_left;
	int counted;

	offset_ramp_tracker sb = new();

	hysteresis_smoother_offset_ramp_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_value(int near, int top);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		if (r == 2)
			return top;
		if (r == 3)
			return $urandom_range(0, top);
		return $urandom_range(0, near);
	endfunction

	function automatic int pick_width();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 31;
		return $urandom_range(1, 16);
	endfunction

	// output side stalls
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (run_left > 0) begin
				out_stall = 1'b0;
				run_left--;
			end else begin
				out_stall = 1'b0;
				stall_left = pick_gap();
				run_left = $urandom_range(0, 10);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(drive_result_t'({smooth_blue, smooth_green, offset_now,
				offset_goal, blue_drive, green_drive}));
	end

	task automatic send_item(hsor_pkg::kind_t op, logic [15:0] b, logic [15:0] g,
			logic signed [15:0] t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		kind = op;
		blue_sample = b;
		green_sample = g;
		new_target = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(op, b, g, t);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(hsor_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic write_reg(hsor_pkg::reg_index_t idx, logic [15:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (sb.expected_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_config();
		write_reg(hsor_pkg::REG_MAX_MAGNITUDE,
			{1'($urandom_range(0, 1)), 15'(pick_value(8, 32767))});
		write_reg(hsor_pkg::REG_TICKS_PER_LEVEL, 16'(pick_value(3, 65535)));
		write_reg(hsor_pkg::REG_TICKS_AT_TARGET, 16'(pick_value(6, 65535)));
		write_reg(hsor_pkg::REG_HYSTERESIS, 16'(pick_value(300, 65535)));
		write_reg(hsor_pkg::REG_ADC_WIDTH, {11'($urandom), 5'(pick_width())});
		write_reg(hsor_pkg::REG_DAC_WIDTH, {11'($urandom), 5'(pick_width())});
	endtask

	task automatic random_item(output bit useful);
		int r, d;
		hsor_pkg::kind_t op;
		logic [15:0] b, g;
		logic signed [15:0] t;
		r = $urandom_range(0, 99);
		op = (r < 35) ? hsor_pkg::KIND_SAMPLE : (r < 52) ? hsor_pkg::KIND_TARGET
			: (r < 96) ? hsor_pkg::KIND_TICK : hsor_pkg::KIND_NONE;
		b = 16'($urandom);
		g = 16'($urandom);
		t = 16'($urandom);
		// readings close to the current levels probe the hysteresis edge
		if ($urandom_range(0, 1)) begin
			d = $urandom_range(0, sb.hyst + 2);
			b = 16'(sb.blue_lvl + ($urandom_range(0, 1) ? d : -d));
		end
		if ($urandom_range(0, 1)) begin
			d = $urandom_range(0, sb.hyst + 2);
			g = 16'(sb.green_lvl + ($urandom_range(0, 1) ? d : -d));
		end
		if ($urandom_range(0, 2) != 0)
			t = 16'(int'($urandom_range(0, 2 * sb.max_mag + 4)) - sb.max_mag - 2);
		useful = (op != hsor_pkg::KIND_NONE);
		send_item(op, b, g, t);
	endtask

	initial begin
		bit useful;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hsor_pkg::REG_MAX_MAGNITUDE;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		kind = hsor_pkg::KIND_SAMPLE;
		blue_sample = 16'd0;
		green_sample = 16'd0;
		new_target = 16'sd0;
		no_idle = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings
		send_item(hsor_pkg::KIND_SAMPLE, 16'h0000, 16'hFFFF, 16'sh0000);
		send_item(hsor_pkg::KIND_SAMPLE, 16'hFFFF, 16'h0000, 16'sh7FFF);
		send_item(hsor_pkg::KIND_NONE, 16'hA5A5, 16'h5A5A, -16'sd1);
		send_item(hsor_pkg::KIND_TARGET, 16'h0000, 16'h0000, 16'sh7FFF);
		send_tick();
		send_tick();
		settle();

		// full magnitude, move on every tick, wide shift down
		write_reg(hsor_pkg::REG_MAX_MAGNITUDE, 16'h7FFF);
		write_reg(hsor_pkg::REG_TICKS_PER_LEVEL, 16'd0);
		write_reg(hsor_pkg::REG_TICKS_AT_TARGET, 16'd0);
		write_reg(hsor_pkg::REG_HYSTERESIS, 16'd0);
		write_reg(hsor_pkg::REG_ADC_WIDTH, 16'd16);
		write_reg(hsor_pkg::REG_DAC_WIDTH, 16'd1);
		send_item(hsor_pkg::KIND_TARGET, 16'hFFFF, 16'hFFFF, 16'sh8000);
		send_tick();
		send_tick();
		send_item(hsor_pkg::KIND_SAMPLE, 16'h0000, 16'hFFFF, 16'sh0000);
		send_item(hsor_pkg::KIND_TARGET, 16'h0000, 16'h0000, 16'sh7FFF);
		repeat (3) send_tick();
		send_item(hsor_pkg::KIND_TARGET, 16'h0000, 16'h0000, 16'sd1);
		send_tick();
		send_tick();
		settle();

		// readings held by full hysteresis, wide shift up
		write_reg(hsor_pkg::REG_HYSTERESIS, 16'hFFFF);
		write_reg(hsor_pkg::REG_ADC_WIDTH, 16'd1);
		write_reg(hsor_pkg::REG_DAC_WIDTH, 16'd16);
		write_reg(hsor_pkg::REG_MAX_MAGNITUDE, 16'h8001);
		send_item(hsor_pkg::KIND_SAMPLE, 16'd1, 16'd1, 16'sd0);
		send_item(hsor_pkg::KIND_TARGET, 16'h0000, 16'h0000, -16'sd1);
		send_tick();
		settle();

		// widths outside the normal range
		write_reg(hsor_pkg::REG_ADC_WIDTH, 16'hFFE0);
		write_reg(hsor_pkg::REG_DAC_WIDTH, 16'hFFFF);
		send_item(hsor_pkg::KIND_SAMPLE, 16'h8000, 16'h7FFF, 16'sd0);
		settle();
		write_reg(hsor_pkg::REG_ADC_WIDTH, 16'd17);
		write_reg(hsor_pkg::REG_DAC_WIDTH, 16'd1);
		send_item(hsor_pkg::KIND_NONE, 16'h1234, 16'h4321, 16'sd0);
		settle();

		// long dwell while a nonzero goal is held
		write_reg(hsor_pkg::REG_TICKS_PER_LEVEL, 16'hFFFF);
		write_reg(hsor_pkg::REG_TICKS_AT_TARGET, 16'hFFFF);
		no_idle = 1'b1;
		repeat (HOLD_TICKS) send_tick();
		settle();
		no_idle = 1'b0;
		write_reg(hsor_pkg::REG_TICKS_AT_TARGET, 16'd0);
		repeat (3) send_tick();
		settle();

		for (int p = 0; p < 8; p++) begin
			random_config();
			no_idle = (p == 3);
			counted = 0;
			while (counted < 125) begin
				random_item(useful);
				if (useful)
					counted++;
			end
			settle();
		end
		no_idle = 1'b0;

		in_valid = 1'b0;
		while (sb.expected_drives.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
